// ===== design/blru_pkg.sv =====
package blru_pkg;

  // Storage is sized by the 4-bit bank field, whatever BANKS is.
  localparam int unsigned BANK_W      = 4;
  localparam int unsigned NUM_ENTRIES = 1 << BANK_W;
  localparam int unsigned OFFSET_W    = 17;
  localparam int unsigned CNT_W       = BANK_W;

  localparam int unsigned DEF_BANKS          = 16;
  localparam int unsigned DEF_RESIDENT_LIMIT = 4;
  localparam int unsigned DEF_BANK_BYTES     = 65536;
  localparam int unsigned DEF_STAMP_BITS     = 32;

  localparam int unsigned SHARED_W = 16;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_SHARED_MASK = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE_BANK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_CHECK       = 2'd2;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_BAD_BANK   = 2'd1;
  localparam logic [1:0] ST_BAD_OFFSET = 2'd2;
  localparam logic [1:0] ST_DENIED     = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FIN,
    S_DONE
  } state_e;

  typedef struct packed {
    logic              start;
    logic              cmp_en;
    logic              resident;
    logic [BANK_W-1:0] idx;
  } scan_ctrl_t;

  typedef struct packed {
    logic [CNT_W-1:0]  count;
    logic              found;
    logic [BANK_W-1:0] victim;
  } scan_stat_t;

endpackage

// ===== design/blru_ram.sv =====
module blru_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/blru_scan.sv =====
module blru_scan import blru_pkg::*; #(
  parameter int unsigned STAMP_BITS = DEF_STAMP_BITS
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  scan_ctrl_t            ctrl_i,
  input  logic [STAMP_BITS-1:0] stamp_i,
  output scan_stat_t            stat_o
);

  // One compare per cycle: counts residents and tracks the oldest stamp.
  logic [CNT_W-1:0]      count_q, count_d;
  logic                  found_q, found_d;
  logic [BANK_W-1:0]     victim_q, victim_d;
  logic [STAMP_BITS-1:0] oldest_q, oldest_d;

  always_comb begin
    count_d  = count_q;
    found_d  = found_q;
    victim_d = victim_q;
    oldest_d = oldest_q;
    if (ctrl_i.start) begin
      count_d  = '0;
      found_d  = 1'b0;
      victim_d = '0;
      oldest_d = '0;
    end else if (ctrl_i.cmp_en && ctrl_i.resident) begin
      count_d = count_q + CNT_W'(1);
      // strict less-than keeps the lowest bank on ties
      if (!found_q || (stamp_i < oldest_q)) begin
        found_d  = 1'b1;
        victim_d = ctrl_i.idx;
        oldest_d = stamp_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      found_q  <= 1'b0;
      victim_q <= '0;
    end else begin
      count_q  <= count_d;
      found_q  <= found_d;
      victim_q <= victim_d;
    end
  end

  always_ff @(posedge clk_i) begin
    oldest_q <= oldest_d;
  end

  assign stat_o.count  = count_q;
  assign stat_o.found  = found_q;
  assign stat_o.victim = victim_q;

endmodule

// ===== design/bank_residency_lru_manager_unit.sv =====
// Bank residency manager, least-recently-used replacement.
//
// Requests come in on the s_axis channel (op, bank, offset); one result per
// request leaves on m_axis (status, hit, victim_valid, victim_bank,
// victim_dirty). Configuration (shared mask, active bank, check enable) is
// written through cfg_we_i/cfg_idx_i/cfg_wdata_i; the user must write it only
// while the block is idle, which the block itself does not enforce.
//
// A rejected request or a hit goes from accept to the DONE state, which loads
// the output register. A miss scans the 15 bank entries through one stamp
// RAM read port and one shared compare unit, one entry per cycle: accept,
// SCAN, DRAIN, the FIN update, then DONE. s_axis_tready is high only while
// the sequencer is idle, so one request is in work at a time.
//
// The result sits in an output register; the next request is accepted while
// a result still waits, and the sequencer holds its finished result until
// the register frees up when the receiver stalls.
//
// Reset clears residency, dirty marks, the use counter and configuration.
module bank_residency_lru_manager_unit import blru_pkg::*; #(
  parameter int unsigned BANKS          = DEF_BANKS,
  parameter int unsigned RESIDENT_LIMIT = DEF_RESIDENT_LIMIT,
  parameter int unsigned BANK_BYTES     = DEF_BANK_BYTES,
  parameter int unsigned STAMP_BITS     = DEF_STAMP_BITS
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  input  logic [23:0]          s_axis_tdata,  // op, bank[3:0], offset[16:0], pad
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  output logic [15:0]          m_axis_tdata,  // status[1:0], hit, victim_valid,
                                              // victim_bank[3:0], victim_dirty, pad
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [SHARED_W-1:0]  cfg_wdata_i
);

  localparam int unsigned BB_W  = $clog2(BANK_BYTES + 1) + 1;
  localparam int unsigned OFS_W = (BB_W > OFFSET_W) ? BB_W : OFFSET_W;
  localparam int unsigned BK_W  = $clog2(BANKS + 1) + 1;
  localparam int unsigned CB_W  = (BK_W > BANK_W) ? BK_W : BANK_W;
  localparam int unsigned LIM_W = $clog2(RESIDENT_LIMIT + 1) + CNT_W;

  // ---- configuration registers
  logic [SHARED_W-1:0] shared_q;
  logic [BANK_W-1:0]   active_q;
  logic                check_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shared_q <= '0;
      active_q <= '0;
      check_q  <= 1'b0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_SHARED_MASK: shared_q <= cfg_wdata_i;
        CFG_ACTIVE_BANK: active_q <= cfg_wdata_i[BANK_W-1:0];
        CFG_CHECK:       check_q  <= cfg_wdata_i[0];
        default: ;
      endcase
    end
  end

  // ---- request fields and the up-front checks
  logic                in_op;
  logic [BANK_W-1:0]   in_bank;
  logic [OFFSET_W-1:0] in_offset;
  logic [1:0]          in_status;
  logic                accept;

  assign in_op     = s_axis_tdata[0];
  assign in_bank   = s_axis_tdata[4:1];
  assign in_offset = s_axis_tdata[21:5];
  assign accept    = s_axis_tvalid && s_axis_tready;

  always_comb begin
    if ((in_bank == '0) || (CB_W'(in_bank) >= CB_W'(BANKS))) begin
      in_status = ST_BAD_BANK;
    end else if (OFS_W'(in_offset) >= OFS_W'(BANK_BYTES)) begin
      in_status = ST_BAD_OFFSET;
    end else if (check_q && (in_bank != active_q) && !shared_q[in_bank]) begin
      in_status = ST_DENIED;
    end else begin
      in_status = ST_OK;
    end
  end

  // ---- state
  state_e state_q, state_d;

  logic [NUM_ENTRIES-1:0] resident_q, resident_d;
  logic [NUM_ENTRIES-1:0] dirty_q, dirty_d;
  logic [STAMP_BITS-1:0]  use_cnt_q, use_cnt_d;

  logic              op_q;
  logic [BANK_W-1:0] bank_q;
  logic [1:0]        res_status_q, res_status_d;
  logic              res_hit_q, res_hit_d;
  logic              res_vvalid_q, res_vvalid_d;
  logic [BANK_W-1:0] res_vbank_q, res_vbank_d;
  logic              res_vdirty_q, res_vdirty_d;

  logic [BANK_W-1:0] idx_q, idx_d;
  logic              cmp_vld_q, cmp_vld_d;
  logic [BANK_W-1:0] cmp_idx_q;

  logic [15:0] out_data_q, out_data_d;
  logic        out_vld_q, out_vld_d;

  scan_ctrl_t            scan_ctrl;
  scan_stat_t            scan_stat;
  logic [STAMP_BITS-1:0] stamp_rd;
  logic                  stamp_we;
  logic                  evict;
  logic                  out_free;
  logic                  load_out;
  logic                  is_miss;

  assign out_free = !out_vld_q || m_axis_tready;
  assign is_miss  = (in_status == ST_OK) && !resident_q[in_bank];
  assign evict    = scan_stat.found
                    && (LIM_W'(scan_stat.count) >= LIM_W'(RESIDENT_LIMIT));

  // ---- sequencer: next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (accept) state_d = is_miss ? S_SCAN : S_DONE;
      S_SCAN:  if (idx_q == BANK_W'(NUM_ENTRIES - 1)) state_d = S_DRAIN;
      S_DRAIN: state_d = S_FIN;
      S_FIN:   state_d = S_DONE;
      S_DONE:  if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // ---- sequencer: outputs
  always_comb begin
    s_axis_tready      = 1'b0;
    stamp_we           = 1'b0;
    load_out           = 1'b0;
    cmp_vld_d          = 1'b0;
    idx_d              = idx_q;
    scan_ctrl.start    = 1'b0;
    scan_ctrl.cmp_en   = cmp_vld_q;
    scan_ctrl.idx      = cmp_idx_q;
    scan_ctrl.resident = resident_q[cmp_idx_q];
    unique case (state_q)
      S_IDLE: begin
        s_axis_tready   = 1'b1;
        stamp_we        = accept && (in_status == ST_OK);
        scan_ctrl.start = accept;
        idx_d           = BANK_W'(1);
      end
      S_SCAN: begin
        cmp_vld_d = 1'b1;
        idx_d     = idx_q + BANK_W'(1);
      end
      S_DRAIN: ;
      S_FIN:   ;
      S_DONE:  load_out = out_free;
      default: ;
    endcase
  end

  // ---- datapath updates
  always_comb begin
    resident_d   = resident_q;
    dirty_d      = dirty_q;
    use_cnt_d    = use_cnt_q;
    res_status_d = res_status_q;
    res_hit_d    = res_hit_q;
    res_vvalid_d = res_vvalid_q;
    res_vbank_d  = res_vbank_q;
    res_vdirty_d = res_vdirty_q;
    if (stamp_we) begin
      if (use_cnt_q != '1) begin
        use_cnt_d = use_cnt_q + STAMP_BITS'(1);
      end
      // a write to a bank already resident marks it dirty now
      if (resident_q[in_bank] && in_op) begin
        dirty_d[in_bank] = 1'b1;
      end
    end
    if (accept) begin
      res_status_d = in_status;
      res_hit_d    = (in_status == ST_OK) && resident_q[in_bank];
      res_vvalid_d = 1'b0;
      res_vbank_d  = '0;
      res_vdirty_d = 1'b0;
    end
    if (state_q == S_FIN) begin
      if (evict) begin
        res_vvalid_d                = 1'b1;
        res_vbank_d                 = scan_stat.victim;
        res_vdirty_d                = dirty_q[scan_stat.victim];
        resident_d[scan_stat.victim] = 1'b0;
        dirty_d[scan_stat.victim]    = 1'b0;
      end
      resident_d[bank_q] = 1'b1;
      dirty_d[bank_q]    = op_q;
    end
  end

  always_comb begin
    out_vld_d  = out_vld_q;
    out_data_d = out_data_q;
    if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end
    if (load_out) begin
      out_vld_d  = 1'b1;
      out_data_d = {7'd0, res_vdirty_q, res_vbank_q, res_vvalid_q, res_hit_q,
                    res_status_q};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      resident_q <= '0;
      dirty_q    <= '0;
      use_cnt_q  <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      resident_q <= resident_d;
      dirty_q    <= dirty_d;
      use_cnt_q  <= use_cnt_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_q   <= in_op;
      bank_q <= in_bank;
    end
    idx_q        <= idx_d;
    cmp_idx_q    <= idx_q;
    res_status_q <= res_status_d;
    res_hit_q    <= res_hit_d;
    res_vvalid_q <= res_vvalid_d;
    res_vbank_q  <= res_vbank_d;
    res_vdirty_q <= res_vdirty_d;
    out_data_q   <= out_data_d;
  end

  // ---- stamp store and the shared compare unit
  // Only resident entries are ever compared, and each was stamped when it
  // became resident, so the store needs no clearing.
  blru_ram #(
    .WIDTH (STAMP_BITS),
    .DEPTH (NUM_ENTRIES)
  ) u_stamp_ram (
    .clk_i   (clk_i),
    .we_i    (stamp_we),
    .waddr_i (in_bank),
    .wdata_i (use_cnt_d),
    .raddr_i (idx_q),
    .rdata_o (stamp_rd)
  );

  blru_scan #(
    .STAMP_BITS (STAMP_BITS)
  ) u_scan (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (scan_ctrl),
    .stamp_i (stamp_rd),
    .stat_o  (scan_stat)
  );

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

  // ---- assertions
  a_limit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ($countones(resident_q) <= RESIDENT_LIMIT) || (RESIDENT_LIMIT >= NUM_ENTRIES))
    else $error("more banks resident than the limit allows");

  a_bank0: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !resident_q[0])
    else $error("bank zero became resident");

  a_dirty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dirty_q & ~resident_q) == '0)
    else $error("dirty mark on a bank that is not resident");

  a_victim: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[3] |-> (m_axis_tdata[1:0] == ST_OK) && !m_axis_tdata[2])
    else $error("victim reported on a hit or rejected request");

  a_evict: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_FIN) && evict |=> !resident_q[$past(scan_stat.victim)])
    else $error("evicted bank still resident");

endmodule
